[rtl/lpfh_pkg.sv]
package lpfh_pkg;

   localparam int PAGE_COUNT  = 64;
   localparam int MAX_FRAMES  = 32;
   localparam int STAMP_BITS  = 32;

   localparam int PAGE_BITS   = $clog2(PAGE_COUNT);
   localparam int CNT_BITS    = $clog2(PAGE_COUNT + 1);
   localparam int HANDED_BITS = $clog2(MAX_FRAMES + 1);

   // fixed by the word fields
   localparam int PAGE_FIELD_BITS = 6;
   localparam int FRAME_BITS      = 5;
   localparam int TIME_BITS       = 32;
   localparam int REQ_BITS        = 16;
   localparam int DISK_BITS       = 32;
   localparam int CFG_BITS        = 6;

   localparam logic [CFG_BITS-1:0] FRAME_COUNT_RESET = CFG_BITS'(32);

   typedef enum logic {
      OP_TOUCH = 1'b0,
      OP_FAULT = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_TOUCHED  = 2'd0,
      ST_FREE     = 2'd1,
      ST_EVICTED  = 2'd2,
      ST_RESIDENT = 2'd3
   } status_type;

   typedef logic [STAMP_BITS-1:0] stamp_type;
   typedef logic [PAGE_BITS-1:0]  page_idx_type;

endpackage

[rtl/lru_page_fault_handler.sv]
// Channel   Ports                                   Handshake
// ------    ------------------------------------    ---------------------------------
// request   req_opcode/page/access_time/...         taken when start && !busy
// response  rsp_status/frame/victim_page/...        rsp_strobe for one cycle, no stall
// config    csr_write_enable, csr_write_data        written on any edge with enable
//
// Touch: busy stays low, response on the next cycle.
// Fault on a free frame: busy stays low. Fault on a resident page: via S_RES_RD (frame RAM read).
// Fault by eviction: the accept cycle, a stamp RAM scan over every entry (one entry per cycle
// through a registered read port), the victim frame read (S_VIC_RD), then the load (S_LOAD).
// Synchronous reset clears valid, dirty and stamp-written bits at once; no clearing pass.
// The receiver cannot stall results.
module lru_page_fault_handler
   import lpfh_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [PAGE_FIELD_BITS-1:0] req_page,
   input  logic [TIME_BITS-1:0]       req_access_time,
   input  logic                       req_write_access,
   input  logic [REQ_BITS-1:0]        req_requester,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [FRAME_BITS-1:0]      rsp_frame,
   output logic [PAGE_FIELD_BITS-1:0] rsp_victim_page,
   output logic                       rsp_write_back,
   output logic [REQ_BITS-1:0]        rsp_requester_out,
   output logic [DISK_BITS-1:0]       rsp_disk_accesses,
   input  logic                       csr_write_enable,
   input  logic [CFG_BITS-1:0]        csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RES_RD,
      S_SCAN,
      S_VIC_RD,
      S_LOAD
   } state_type;

   // memories
   stamp_type                 stamp_mem [PAGE_COUNT];
   logic [FRAME_BITS-1:0]     frame_mem [PAGE_COUNT];

   logic                      stamp_we;
   page_idx_type              stamp_waddr;
   stamp_type                 stamp_wdata;
   page_idx_type              stamp_raddr;
   stamp_type                 stamp_rdata_ff;

   logic                      frame_we;
   page_idx_type              frame_waddr;
   logic [FRAME_BITS-1:0]     frame_wdata;
   page_idx_type              frame_raddr;
   logic [FRAME_BITS-1:0]     frame_rdata_ff;

   // control and table state
   state_type                 state_ff, state_in;
   logic [PAGE_COUNT-1:0]     valid_ff, valid_in;
   logic [PAGE_COUNT-1:0]     dirty_ff, dirty_in;
   logic [PAGE_COUNT-1:0]     stamp_wr_ff, stamp_wr_in;
   logic                      stamp_hit_ff;
   logic [HANDED_BITS-1:0]    handed_ff, handed_in;
   logic [DISK_BITS-1:0]      disk_ff, disk_in;
   logic [CFG_BITS-1:0]       cfg_ff, cfg_in;

   page_idx_type              pg_ff, pg_in;
   logic [REQ_BITS-1:0]       req_ff, req_in;

   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                      eval_vld_ff, eval_vld_in;
   page_idx_type              eval_idx_ff, eval_idx_in;
   logic                      found_ff, found_in;
   page_idx_type              best_ff, best_in;
   stamp_type                 best_stamp_ff, best_stamp_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [FRAME_BITS-1:0]     rsp_frame_ff, rsp_frame_in;
   logic [PAGE_FIELD_BITS-1:0] rsp_victim_ff, rsp_victim_in;
   logic                      rsp_wb_ff, rsp_wb_in;
   logic [REQ_BITS-1:0]       rsp_req_ff, rsp_req_in;
   logic [DISK_BITS-1:0]      rsp_disk_ff, rsp_disk_in;

   // combinational helpers
   page_idx_type              req_idx;
   logic [HANDED_BITS-1:0]    limit;
   stamp_type                 cur_stamp;
   logic                      take;
   logic                      vic_dirty;
   logic [FRAME_BITS-1:0]     load_frame;
   logic [DISK_BITS:0]        disk_sum;
   logic [DISK_BITS-1:0]      disk_load;
   logic [DISK_BITS-1:0]      disk_one;

   assign req_idx = PAGE_BITS'(req_page % PAGE_COUNT);

   always_comb begin
      if (cfg_ff == '0) begin
         limit = HANDED_BITS'(1);
      end else if (int'(cfg_ff) > MAX_FRAMES) begin
         limit = HANDED_BITS'(MAX_FRAMES);
      end else begin
         limit = HANDED_BITS'(cfg_ff);
      end
   end

   // never-written stamps read as zero
   assign cur_stamp = stamp_hit_ff ? stamp_rdata_ff : '0;
   assign take      = eval_vld_ff && valid_ff[eval_idx_ff] &&
                      (!found_ff || (cur_stamp < best_stamp_ff));

   assign vic_dirty  = found_ff && dirty_ff[best_ff];
   assign load_frame = found_ff ? frame_rdata_ff : '0;
   // one load plus an optional write-back, saturating
   assign disk_sum   = {1'b0, disk_ff} + (vic_dirty ? (DISK_BITS+1)'(2) : (DISK_BITS+1)'(1));
   assign disk_load  = disk_sum[DISK_BITS] ? '1 : disk_sum[DISK_BITS-1:0];
   assign disk_one   = (disk_ff == '1) ? disk_ff : disk_ff + DISK_BITS'(1);

   assign stamp_raddr = cnt_ff[PAGE_BITS-1:0];
   assign frame_raddr = (state_ff == S_IDLE) ? req_idx : best_ff;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      stamp_wr_in   = stamp_wr_ff;
      handed_in     = handed_ff;
      disk_in       = disk_ff;
      cfg_in        = csr_write_enable ? csr_write_data : cfg_ff;
      pg_in         = pg_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_wb_in     = rsp_wb_ff;
      rsp_req_in    = rsp_req_ff;
      rsp_disk_in   = rsp_disk_ff;

      stamp_we      = 1'b0;
      stamp_waddr   = req_idx;
      stamp_wdata   = stamp_type'(req_access_time);
      frame_we      = 1'b0;
      frame_waddr   = req_idx;
      frame_wdata   = handed_ff[FRAME_BITS-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               pg_in  = req_idx;
               req_in = req_requester;
               if (opcode_type'(req_opcode) == OP_TOUCH) begin
                  stamp_we             = 1'b1;
                  stamp_wr_in[req_idx] = 1'b1;
                  if (req_write_access) begin
                     dirty_in[req_idx] = 1'b1;
                  end
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_TOUCHED;
                  rsp_frame_in  = '0;
                  rsp_victim_in = '0;
                  rsp_wb_in     = 1'b0;
                  rsp_req_in    = '0;
                  rsp_disk_in   = disk_ff;
               end else if (valid_ff[req_idx]) begin
                  state_in = S_RES_RD;
               end else if (handed_ff < limit) begin
                  frame_we          = 1'b1;
                  valid_in[req_idx] = 1'b1;
                  dirty_in[req_idx] = 1'b0;
                  handed_in         = handed_ff + HANDED_BITS'(1);
                  disk_in           = disk_one;
                  rsp_strobe_in     = 1'b1;
                  rsp_status_in     = ST_FREE;
                  rsp_frame_in      = handed_ff[FRAME_BITS-1:0];
                  rsp_victim_in     = '0;
                  rsp_wb_in         = 1'b0;
                  rsp_req_in        = req_requester;
                  rsp_disk_in       = disk_one;
               end else begin
                  state_in = S_SCAN;
                  cnt_in   = '0;
                  found_in = 1'b0;
               end
            end
         end
         S_RES_RD: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_RESIDENT;
            rsp_frame_in  = frame_rdata_ff;
            rsp_victim_in = '0;
            rsp_wb_in     = 1'b0;
            rsp_req_in    = req_ff;
            rsp_disk_in   = disk_ff;
         end
         S_SCAN: begin
            if (take) begin
               found_in      = 1'b1;
               best_in       = eval_idx_ff;
               best_stamp_in = cur_stamp;
            end
            if (cnt_ff == CNT_BITS'(PAGE_COUNT)) begin
               state_in = S_VIC_RD;
            end else begin
               eval_vld_in = 1'b1;
               eval_idx_in = cnt_ff[PAGE_BITS-1:0];
               cnt_in      = cnt_ff + CNT_BITS'(1);
            end
         end
         S_VIC_RD: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in        = S_IDLE;
            frame_we        = 1'b1;
            frame_waddr     = pg_ff;
            frame_wdata     = load_frame;
            if (found_ff) begin
               valid_in[best_ff] = 1'b0;
               dirty_in[best_ff] = 1'b0;
            end
            valid_in[pg_ff] = 1'b1;
            dirty_in[pg_ff] = 1'b0;
            disk_in         = disk_load;
            rsp_strobe_in   = 1'b1;
            rsp_status_in   = found_ff ? ST_EVICTED : ST_FREE;
            rsp_frame_in    = load_frame;
            rsp_victim_in   = found_ff ? PAGE_FIELD_BITS'(best_ff) : '0;
            rsp_wb_in       = vic_dirty;
            rsp_req_in      = req_ff;
            rsp_disk_in     = disk_load;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[stamp_waddr] <= stamp_wdata;
      end
      stamp_rdata_ff <= stamp_mem[stamp_raddr];
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      frame_rdata_ff <= frame_mem[frame_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         stamp_wr_ff   <= '0;
         stamp_hit_ff  <= 1'b0;
         handed_ff     <= '0;
         disk_ff       <= '0;
         cfg_ff        <= FRAME_COUNT_RESET;
         eval_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         stamp_wr_ff   <= stamp_wr_in;
         stamp_hit_ff  <= stamp_wr_ff[stamp_raddr];
         handed_ff     <= handed_in;
         disk_ff       <= disk_in;
         cfg_ff        <= cfg_in;
         eval_vld_ff   <= eval_vld_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pg_ff         <= pg_in;
      req_ff        <= req_in;
      cnt_ff        <= cnt_in;
      eval_idx_ff   <= eval_idx_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_wb_ff     <= rsp_wb_in;
      rsp_req_ff    <= rsp_req_in;
      rsp_disk_ff   <= rsp_disk_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_victim_page   = rsp_victim_ff;
   assign rsp_write_back    = rsp_wb_ff;
   assign rsp_requester_out = rsp_req_ff;
   assign rsp_disk_accesses = rsp_disk_ff;

endmodule
